// ----- hw/rtl/stg_pkg.sv -----
// Package for the square-root trajectory generator.
// Holds the transfer structs, fixed field widths, register index and operation codes.
// Used by sqrt_trajectory_generator_top; depends on nothing.
package stg_pkg;

  localparam int VEL_W      = 40;  // signed Q16.24 velocity
  localparam int SP_OUT_W   = 56;  // signed Q32.24 setpoint on the result channel
  localparam int DECEL_W    = 32;
  localparam int SPEED_W    = 39;
  localparam int STEP_W     = 24;
  localparam int TGT_W      = 32;
  localparam int MUL_W      = 32;  // operand width of the shared multiplier
  localparam int ROOT_BITS  = 49;  // root bits produced by the square root
  localparam int RAD_W      = 2 * ROOT_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 39;

  localparam logic [CFG_IDX_W-1:0] CFG_DECEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL     = 2'd2;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  localparam logic [DECEL_W-1:0] DECEL_RESET = 32'd1677;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 39'd16777216;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd1677;

  typedef struct packed {
    logic                    operation;
    logic signed [TGT_W-1:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic signed [SP_OUT_W-1:0] new_setpoint;
    logic signed [VEL_W-1:0]    new_velocity;
    logic                       snapped;
  } out_item_t;

endpackage

// ----- hw/rtl/sqrt_trajectory_generator_top.sv -----
// Square-root trajectory generator, top level and only module.
// Shared 32x32 multiplier, one-pair-per-cycle square root, ramp and integrator.
// Depends on stg_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_item_t (operation, target)
//  out     | output    | out_valid_o/out_stall_i | out_item_t (setpoint, vel, snap)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A control tick goes from transfer to result through the error step, the multiplier
// steps MUL0, MUL1 and MUL2 for the two 32x32 partial products, the square-root steps
// (one root bit per cycle), then the ramp, integrate and output steps.
// A preset or a snap skips to the output step. The input stalls while an item is at work.
// A finished result waits in the output register; the next item is taken while it waits.
// Reset clears the setpoint, velocity, control state and loads the register defaults.
module sqrt_trajectory_generator_top
  import stg_pkg::*;
#(
  parameter int FRAC_BITS     = 24,
  parameter int POSITION_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Setpoint width and the width of the integrator sum.
  localparam int SPW   = POSITION_BITS + FRAC_BITS;
  localparam int SUM_W = ((SPW > VEL_W) ? SPW : VEL_W) + 1;
  localparam int CNT_W = $clog2(ROOT_BITS);
  localparam int REM_W = ROOT_BITS + 1;

  localparam logic signed [SUM_W-1:0] SP_MAX =
    {{(SUM_W-SPW+1){1'b0}}, {(SPW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SP_MIN =
    {{(SUM_W-SPW+1){1'b1}}, {(SPW-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_BITS - 1);

  // Sequencer codes.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ERR   = 4'd1;
  localparam logic [3:0] ST_MUL0  = 4'd2;
  localparam logic [3:0] ST_MUL1  = 4'd3;
  localparam logic [3:0] ST_MUL2  = 4'd4;
  localparam logic [3:0] ST_SQRT  = 4'd5;
  localparam logic [3:0] ST_RAMP  = 4'd6;
  localparam logic [3:0] ST_INTEG = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  // Control state.
  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // Configuration registers.
  logic [DECEL_W-1:0] decel_q;
  logic [SPEED_W-1:0] max_speed_q;
  logic [STEP_W-1:0]  step_q;

  // Architectural state.
  logic signed [SPW-1:0]   sp_q, sp_d;
  logic signed [VEL_W-1:0] vel_q, vel_d;

  // Working registers.
  logic                  op_q, op_d;
  logic signed [SPW-1:0] tgt_q, tgt_d;
  logic [63:0]           aerr_q, aerr_d;
  logic                  neg_q, neg_d;
  logic                  snap_q, snap_d;
  logic [63:0]           prod_q, prod_d;
  logic [95:0]           acc_q, acc_d;
  logic [RAD_W-1:0]      rad_q, rad_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ROOT_BITS-1:0]  root_q, root_d;
  out_item_t             out_q, out_d;

  // Datapath signals.
  logic                   in_xfer;
  logic                   out_free;
  logic signed [SPW:0]    err;
  logic [SPW:0]           err_abs;
  logic [MUL_W-1:0]       mul_a;
  logic [63:0]            prod;
  logic [95:0]            prod_sum;
  logic [REM_W+1:0]       rem_sh;
  logic [REM_W+1:0]       trial;
  logic                   ge;
  logic [REM_W+1:0]       rem_sub;
  logic [SPEED_W-1:0]     spd;
  logic signed [VEL_W:0]  want;
  logic signed [VEL_W:0]  vel_ext;
  logic signed [VEL_W:0]  step_s;
  logic signed [VEL_W:0]  diff;
  logic signed [VEL_W:0]  vel_up;
  logic signed [VEL_W:0]  vel_dn;
  logic signed [SUM_W-1:0] np;
  logic signed [SUM_W-1:0] np_sat;
  logic signed [63:0]     sp_wide;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Error against the stored setpoint and its magnitude.
  assign err     = {tgt_q[SPW-1], tgt_q} - {sp_q[SPW-1], sp_q};
  assign err_abs = err[SPW] ? (~err + 1'b1) : err;

  // Shared multiplier: low half of the error first, then the high half.
  assign mul_a    = (state_q == ST_MUL0) ? aerr_q[31:0] : aerr_q[63:32];
  assign prod     = decel_q * mul_a;
  assign prod_sum = acc_q + {prod_q, 32'b0};

  // Square root step: bring in two radicand bits, try (root << 2) | 1.
  assign rem_sh  = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial   = (REM_W+2)'({root_q, 2'b01});
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  // Clamp, sign and ramp.
  assign spd     = (root_q > ROOT_BITS'(max_speed_q)) ? max_speed_q : root_q[SPEED_W-1:0];
  assign want    = neg_q ? -$signed({2'b0, spd}) : $signed({2'b0, spd});
  assign vel_ext = (VEL_W+1)'(vel_q);
  assign step_s  = $signed({{(VEL_W+1-STEP_W){1'b0}}, step_q});
  assign diff    = want - vel_ext;
  assign vel_up  = vel_ext + step_s;
  assign vel_dn  = vel_ext - step_s;

  // Integrate and saturate to the setpoint range.
  assign np      = SUM_W'(sp_q) + SUM_W'(vel_q);
  assign np_sat  = (np > SP_MAX) ? SP_MAX : ((np < SP_MIN) ? SP_MIN : np);
  assign sp_wide = 64'(sp_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    sp_d        = sp_q;
    vel_d       = vel_q;
    op_d        = op_q;
    tgt_d       = tgt_q;
    aerr_d      = aerr_q;
    neg_d       = neg_q;
    snap_d      = snap_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    out_d       = out_q;

    // Drop the result once it is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d    = in_data_i.operation;
          tgt_d   = {in_data_i.target_position[POSITION_BITS-1:0], {FRAC_BITS{1'b0}}};
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        aerr_d = 64'(err_abs[SPW-1:0]);
        neg_d  = err[SPW];
        // Preset, or snap when within half a count.
        if ((op_q == OP_PRESET) || ((err_abs >> (FRAC_BITS - 1)) == '0)) begin
          sp_d    = tgt_q;
          vel_d   = '0;
          snap_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          snap_d  = 1'b0;
          state_d = ST_MUL0;
        end
      end
      ST_MUL0: begin
        // Low partial product from the registered error.
        prod_d  = prod;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        acc_d   = 96'(prod_q);
        prod_d  = prod;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        // Radicand is twice the product.
        rad_d   = {1'b0, prod_sum, 1'b0};
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = CNT_LAST;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        rem_d  = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_d = {root_q[ROOT_BITS-2:0], ge};
        rad_d  = {rad_q[RAD_W-3:0], 2'b00};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_RAMP;
        end
      end
      ST_RAMP: begin
        if (diff > step_s) begin
          vel_d = vel_up[VEL_W-1:0];
        end else if (diff < -step_s) begin
          vel_d = vel_dn[VEL_W-1:0];
        end else begin
          vel_d = want[VEL_W-1:0];
        end
        state_d = ST_INTEG;
      end
      ST_INTEG: begin
        sp_d    = np_sat[SPW-1:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_d.new_setpoint = sp_wide[SP_OUT_W-1:0];
          out_d.new_velocity = vel_q;
          out_d.snapped      = snap_q;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      sp_q        <= '0;
      vel_q       <= '0;
      decel_q     <= DECEL_RESET;
      max_speed_q <= SPEED_RESET;
      step_q      <= STEP_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      sp_q        <= sp_d;
      vel_q       <= vel_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_DECEL:     decel_q     <= cfg_data_i[DECEL_W-1:0];
          CFG_MAX_SPEED: max_speed_q <= cfg_data_i[SPEED_W-1:0];
          CFG_ACCEL:     step_q      <= cfg_data_i[STEP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    tgt_q  <= tgt_d;
    aerr_q <= aerr_d;
    neg_q  <= neg_d;
    snap_q <= snap_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    out_q  <= out_d;
  end

endmodule

// ----- sim/sqrt_trajectory_generator_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sqrt_trajectory_generator_top: setpoint trajectories checked
// against an in-bench motion predictor, with random idling on both channels.
// Depends on stg_pkg and the sqrt_trajectory_generator_top RTL.
module sqrt_trajectory_generator_top_test;
  import stg_pkg::*;

  localparam int FRAC = 24;
  // Setpoint saturates to the signed range of POSITION_BITS + FRAC_BITS = 56 bits.
  localparam longint SP_HI = (64'sd1 <<< 55) - 64'sd1;
  localparam longint SP_LO = -(64'sd1 <<< 55);
  localparam int LIMIT = 1_000_000;
  localparam int IDLE_PCT = 32;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 186;
  localparam int TAIL_CYCLES = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Targets not yet offered, and results predicted but not yet seen.
  in_item_t targets_waiting[$];
  out_item_t motion_due[$];

  // Predictor copy of the limit registers and of the motion state.
  logic [DECEL_W-1:0] decel_lim = DECEL_RESET;
  logic [SPEED_W-1:0] speed_lim = SPEED_RESET;
  logic [STEP_W-1:0] step_lim = STEP_RESET;
  longint setpoint_now = 0;
  longint velocity_now = 0;

  int mismatches = 0;
  int items_taken = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic calm;

  sqrt_trajectory_generator_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A window of transfers in which neither side idles at all.
  assign calm = (items_taken >= 700) && (items_taken < 950);

  // floor(sqrt(2 * decel * distance)), bit by bit over 49 root bits on the exact product.
  function automatic logic [63:0] stop_velocity(input logic [63:0] decel,
                                                input logic [63:0] distance);
    logic [127:0] radicand;
    logic [127:0] cand;
    logic [127:0] root;
    radicand = (128'(decel) * 128'(distance)) << 1;
    root = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= radicand) root = cand;
    end
    return root[63:0];
  endfunction

  // Advance the motion state by one input item and return the result it produces.
  function automatic out_item_t next_motion(input in_item_t it);
    out_item_t res;
    longint tgt;
    longint err;
    longint distance;
    longint want;
    longint diff;
    longint step;
    longint np;
    logic [63:0] speed;
    bit snap;
    tgt = longint'(it.target_position);
    tgt = tgt * (64'sd1 <<< FRAC);
    snap = 1'b0;
    if (it.operation == OP_PRESET) begin
      setpoint_now = tgt;
      velocity_now = 0;
      snap = 1'b1;
    end else begin
      err = tgt - setpoint_now;
      distance = (err < 0) ? -err : err;
      if (distance < (64'sd1 <<< (FRAC - 1))) begin
        // Within half a count: land on the target and stop.
        setpoint_now = tgt;
        velocity_now = 0;
        snap = 1'b1;
      end else begin
        speed = stop_velocity(64'(decel_lim), distance);
        if (speed > 64'(speed_lim)) speed = 64'(speed_lim);
        want = (err > 0) ? longint'(speed) : -longint'(speed);
        step = longint'(64'(step_lim));
        diff = want - velocity_now;
        if (diff > step) velocity_now = velocity_now + step;
        else if (diff < -step) velocity_now = velocity_now - step;
        else velocity_now = want;
        np = setpoint_now + velocity_now;
        if (np > SP_HI) np = SP_HI;
        if (np < SP_LO) np = SP_LO;
        setpoint_now = np;
      end
    end
    res.new_setpoint = setpoint_now[SP_OUT_W-1:0];
    res.new_velocity = velocity_now[VEL_W-1:0];
    res.snapped = snap;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 50) $display("%s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Driver: offer queued targets, hold each one until its transfer, and predict on transfer.
  always @(posedge clk_i) begin : feed_targets
    bit slot_free;
    if (rst_ni) begin
      slot_free = !in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        motion_due.push_back(next_motion(in_data_i));
        items_taken <= items_taken + 1;
        slot_free = 1'b1;
      end
      // Drop valid or present the next target; a stalled item stays as it is.
      if (slot_free) begin
        if (targets_waiting.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          in_data_i <= targets_waiting.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off: once enough transfers are in, stall the output for a
  // long stretch so the output register fills and the input stalls too.
  always @(posedge clk_i) begin : receiver_hold
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= 400) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end
  end

  // Monitor: compare every result transfer with the oldest prediction, then pick the stall.
  always @(posedge clk_i) begin : check_results
    out_item_t got;
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (motion_due.size() == 0) begin
          report_mismatch("result with nothing expected", 64'(got.new_setpoint), '0);
        end else begin
          want = motion_due.pop_front();
          if (got.new_setpoint !== want.new_setpoint)
            report_mismatch("new_setpoint", 64'(got.new_setpoint), 64'(want.new_setpoint));
          if (got.new_velocity !== want.new_velocity)
            report_mismatch("new_velocity", 64'(got.new_velocity), 64'(want.new_velocity));
          if (got.snapped !== want.snapped)
            report_mismatch("snapped", 64'(got.snapped), 64'(want.snapped));
        end
      end
      out_stall_i <= (hold_left != 0) || (!calm && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("sqrt_trajectory_generator_top: mismatch");
      $finish;
    end
  end

  function automatic void queue_target(input bit op, input logic [31:0] tgt);
    in_item_t it;
    it.operation = op;
    it.target_position = tgt;
    targets_waiting.push_back(it);
  endfunction

  // Write one limit register and mirror it into the predictor; unknown indexes are ignored.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DECEL:     decel_lim = value[DECEL_W-1:0];
      CFG_MAX_SPEED: speed_lim = value[SPEED_W-1:0];
      CFG_ACCEL:     step_lim = value[STEP_W-1:0];
      default: ;
    endcase
  endtask

  // Junk above the register width must be dropped by the block.
  task automatic set_limits(input logic [DECEL_W-1:0] decel, input logic [SPEED_W-1:0] speed,
                            input logic [STEP_W-1:0] step);
    write_reg(CFG_DECEL, {7'($urandom), decel});
    write_reg(CFG_MAX_SPEED, speed);
    write_reg(CFG_ACCEL, {15'($urandom), step});
  endtask

  // Wait until every target is in and every result is out, then let the block settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (targets_waiting.size() != 0 || in_valid_i || motion_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_offset();
    logic [31:0] mag;
    mag = ($urandom_range(1) != 0) ? 32'($urandom_range(50)) : 32'($urandom_range(2000));
    return ($urandom_range(1) != 0) ? -mag : mag;
  endfunction

  // Mostly well-formed moves: a preset, then a run of ticks toward a nearby goal that
  // sometimes moves mid-run. The rest is noise across the full target range.
  task automatic fill_phase(input int quota);
    int n;
    int run_len;
    logic [31:0] base;
    logic [31:0] goal;
    @(negedge clk_i);
    n = 0;
    while (n < quota) begin
      if ($urandom_range(99) < 15) begin
        queue_target(($urandom_range(3) == 0) ? OP_PRESET : OP_TICK, $urandom);
        n++;
      end else begin
        base = ($urandom_range(99) < 70) ? 32'($urandom_range(200000)) - 32'd100000 : $urandom;
        goal = base + pick_offset();
        queue_target(OP_PRESET, base);
        run_len = $urandom_range(60, 10);
        for (int k = 0; k < run_len; k++) begin
          if ($urandom_range(99) < 8) goal = base + pick_offset();
          queue_target(OP_TICK, goal);
        end
        n += run_len + 1;
      end
    end
  endtask

  initial begin : run_sequence
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, at reset limits: zero error, one-count step, full-range errors both ways.
    @(negedge clk_i);
    queue_target(OP_PRESET, 32'd0);
    queue_target(OP_TICK, 32'd0);
    queue_target(OP_TICK, 32'd1);
    queue_target(OP_TICK, 32'd0);
    queue_target(OP_PRESET, 32'h7fff_ffff);
    queue_target(OP_PRESET, 32'h8000_0000);
    queue_target(OP_TICK, 32'h7fff_ffff);
    queue_target(OP_TICK, 32'h8000_0000);
    queue_target(OP_TICK, 32'hffff_ffff);
    wait_drained();

    // Directed, at full limits: accelerate into the ends of the range so the
    // integrated setpoint overshoots and saturates high, then low.
    set_limits('1, '1, '1);
    @(negedge clk_i);
    queue_target(OP_PRESET, 32'h7fff_ffef);
    repeat (7) queue_target(OP_TICK, 32'h7fff_ffff);
    queue_target(OP_PRESET, 32'h8000_0010);
    repeat (7) queue_target(OP_TICK, 32'h8000_0000);
    wait_drained();

    // Random phases, each under its own limits, written only while the block is idle.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_limits(DECEL_RESET, SPEED_RESET, STEP_RESET);
        1: set_limits('1, '1, '1);
        2: set_limits('0, '0, '0);
        3, 6: set_limits($urandom, 39'({$urandom, $urandom}), 24'($urandom));
        default: set_limits($urandom_range(32'h0400_0000, 32'h0001_0000),
                            39'($urandom_range(32'h4000_0000, 32'h0010_0000)),
                            24'($urandom_range(24'hff_ffff, 24'h00_4000)));
      endcase
      if (p % 2 == 1) write_reg(CFG_UNUSED, 39'({$urandom, $urandom}));
      fill_phase(PHASE_ITEMS);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sqrt_trajectory_generator_top: match");
    end else begin
      $display("sqrt_trajectory_generator_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/stg_pkg.sv
hw/rtl/sqrt_trajectory_generator_top.sv
sim/sqrt_trajectory_generator_top_test.sv
